// File: rtl/core/spat_pkg.sv
`default_nettype none

package spat_pkg;

  // Table depths
  localparam int GDT_DEPTH  = 256;
  localparam int LDT_DEPTH  = 256;
  localparam int DIR_DEPTH  = 1024;
  localparam int PTAB_DEPTH = 1024;

  localparam int GDT_AW  = (GDT_DEPTH > 1) ? $clog2(GDT_DEPTH) : 1;
  localparam int LDT_AW  = (LDT_DEPTH > 1) ? $clog2(LDT_DEPTH) : 1;
  localparam int DIR_AW  = (DIR_DEPTH > 1) ? $clog2(DIR_DEPTH) : 1;
  localparam int PTAB_AW = (PTAB_DEPTH > 1) ? $clog2(PTAB_DEPTH) : 1;

  // Command queue between front and back
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // Descriptor layout
  localparam int DESC_P_BIT       = 47;
  localparam int DESC_LIM_HI_LSB  = 48;
  localparam int DESC_G_BIT       = 55;
  localparam int DESC_BASE_HI_LSB = 56;
  localparam int DESC_BASE_LO_LSB = 16;

  // Linear address split
  localparam int DIR_SHIFT  = 22;
  localparam int PAGE_SHIFT = 12;

  localparam int SEL_IDX_W = 13;
  localparam int PTE_W     = 21;

  // Opcodes
  localparam logic [2:0] OP_TRANSLATE = 3'd0;
  localparam logic [2:0] OP_WR_GDT    = 3'd1;
  localparam logic [2:0] OP_WR_LDT    = 3'd2;
  localparam logic [2:0] OP_WR_DIR    = 3'd3;
  localparam logic [2:0] OP_WR_PTAB   = 3'd4;

  // Configuration register indexes
  localparam logic [1:0] REG_GDT_COUNT  = 2'd0;
  localparam logic [1:0] REG_LDT_COUNT  = 2'd1;
  localparam logic [1:0] REG_DIR_COUNT  = 2'd2;
  localparam logic [1:0] REG_PTAB_COUNT = 2'd3;

  typedef enum logic [2:0] {
    FLT_OK     = 3'd0,
    FLT_NULL   = 3'd1,
    FLT_INDEX  = 3'd2,
    FLT_ABSENT = 3'd3,
    FLT_LIMIT  = 3'd4,
    FLT_DIR    = 3'd5,
    FLT_PAGE   = 3'd6
  } fault_t;

  typedef enum logic [2:0] {
    CMD_RESULT,
    CMD_LOOKUP,
    CMD_WR_GDT,
    CMD_WR_LDT,
    CMD_WR_DIR,
    CMD_WR_PTAB
  } cmd_kind_t;

  typedef enum logic [1:0] {
    B_IDLE,
    B_DESC,
    B_PAGE
  } back_state_t;

  typedef struct packed {
    cmd_kind_t              kind;
    fault_t                 fault;
    logic                   ti;
    logic [SEL_IDX_W-1:0]   sel_idx;
    logic [31:0]            seg_offset;
    logic [9:0]             entry_index;
    logic [63:0]            entry_data;
  } cmd_t;

  typedef struct packed {
    logic full;
    logic empty;
  } q_stat_t;

endpackage

`default_nettype wire

// File: rtl/core/spat_if.sv
`default_nettype none

interface spat_in_if;
  logic        valid;
  logic        ready;
  logic [2:0]  opcode;
  logic [9:0]  entry_index;
  logic [63:0] entry_data;
  logic [15:0] selector;
  logic [31:0] seg_offset;

  modport source (output valid, opcode, entry_index, entry_data, selector, seg_offset,
                  input ready);
  modport sink (input valid, opcode, entry_index, entry_data, selector, seg_offset,
                output ready);
endinterface

interface spat_out_if;
  logic        valid;
  logic        ready;
  logic [2:0]  fault;
  logic [31:0] phys_addr;

  modport source (output valid, fault, phys_addr, input ready);
  modport sink (input valid, fault, phys_addr, output ready);
endinterface

`default_nettype wire

// File: rtl/core/spat_front.sv
`default_nettype none

module spat_front (
  spat_in_if.sink          in_ch,
  input  logic [8:0]       gdt_count,
  input  logic [8:0]       ldt_count,
  input  spat_pkg::q_stat_t q_stat,
  output logic             push,
  output spat_pkg::cmd_t   push_cmd
);

  logic                            ti;
  logic [spat_pkg::SEL_IDX_W-1:0]  idx;
  logic                            idx_bad;

  assign in_ch.ready = !q_stat.full;
  assign push        = in_ch.valid && !q_stat.full;

  assign ti  = in_ch.selector[2];
  assign idx = in_ch.selector[15:3];

  always_comb begin
    if (ti) begin
      idx_bad = (idx >= {4'b0, ldt_count}) || ({1'b0, idx} >= 14'(spat_pkg::LDT_DEPTH));
    end else begin
      idx_bad = (idx >= {4'b0, gdt_count}) || ({1'b0, idx} >= 14'(spat_pkg::GDT_DEPTH));
    end
  end

  always_comb begin
    push_cmd.kind        = spat_pkg::CMD_RESULT;
    push_cmd.fault       = spat_pkg::FLT_OK;
    push_cmd.ti          = ti;
    push_cmd.sel_idx     = idx;
    push_cmd.seg_offset  = in_ch.seg_offset;
    push_cmd.entry_index = in_ch.entry_index;
    push_cmd.entry_data  = in_ch.entry_data;
    case (in_ch.opcode)
      spat_pkg::OP_TRANSLATE: begin
        if (in_ch.selector == 16'd0 || (!ti && idx == '0)) begin
          push_cmd.fault = spat_pkg::FLT_NULL;
        end else if (idx_bad) begin
          push_cmd.fault = spat_pkg::FLT_INDEX;
        end else begin
          push_cmd.kind = spat_pkg::CMD_LOOKUP;
        end
      end
      // writes past the end of a table are dropped but still answered
      spat_pkg::OP_WR_GDT: begin
        if ({4'b0, in_ch.entry_index} < 14'(spat_pkg::GDT_DEPTH)) begin
          push_cmd.kind = spat_pkg::CMD_WR_GDT;
        end
      end
      spat_pkg::OP_WR_LDT: begin
        if ({4'b0, in_ch.entry_index} < 14'(spat_pkg::LDT_DEPTH)) begin
          push_cmd.kind = spat_pkg::CMD_WR_LDT;
        end
      end
      spat_pkg::OP_WR_DIR: begin
        if ({1'b0, in_ch.entry_index} < 11'(spat_pkg::DIR_DEPTH)) begin
          push_cmd.kind = spat_pkg::CMD_WR_DIR;
        end
      end
      spat_pkg::OP_WR_PTAB: begin
        if ({1'b0, in_ch.entry_index} < 11'(spat_pkg::PTAB_DEPTH)) begin
          push_cmd.kind = spat_pkg::CMD_WR_PTAB;
        end
      end
      default: ;
    endcase
  end

endmodule

`default_nettype wire

// File: rtl/core/spat_queue.sv
`default_nettype none

module spat_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  spat_pkg::cmd_t    push_cmd,
  input  logic              pop,
  output spat_pkg::cmd_t    head,
  output spat_pkg::q_stat_t stat
);

  spat_pkg::cmd_t                slot_r [spat_pkg::QUEUE_DEPTH];
  logic [spat_pkg::QPTR_W-1:0]   wr_ptr_r, wr_ptr_nxt;
  logic [spat_pkg::QPTR_W-1:0]   rd_ptr_r, rd_ptr_nxt;
  logic [spat_pkg::QCNT_W-1:0]   cnt_r, cnt_nxt;

  assign head       = slot_r[rd_ptr_r];
  assign stat.full  = (cnt_r == spat_pkg::QCNT_W'(spat_pkg::QUEUE_DEPTH));
  assign stat.empty = (cnt_r == '0);

  always_comb begin
    wr_ptr_nxt = wr_ptr_r;
    rd_ptr_nxt = rd_ptr_r;
    cnt_nxt    = cnt_r;
    if (push) begin
      wr_ptr_nxt = (wr_ptr_r == spat_pkg::QPTR_W'(spat_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : wr_ptr_r + 1'b1;
    end
    if (pop) begin
      rd_ptr_nxt = (rd_ptr_r == spat_pkg::QPTR_W'(spat_pkg::QUEUE_DEPTH - 1)) ?
                   '0 : rd_ptr_r + 1'b1;
    end
    case ({push, pop})
      2'b10:   cnt_nxt = cnt_r + 1'b1;
      2'b01:   cnt_nxt = cnt_r - 1'b1;
      default: cnt_nxt = cnt_r;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      cnt_r    <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wr_ptr_r] <= push_cmd;
    end
  end

endmodule

`default_nettype wire

// File: rtl/core/spat_back.sv
`default_nettype none

module spat_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic [10:0]       dir_count,
  input  logic [10:0]       ptab_count,
  input  spat_pkg::cmd_t    head,
  input  spat_pkg::q_stat_t q_stat,
  output logic              pop,
  spat_out_if.source        out_ch
);

  // Tables
  logic [63:0]              gdt_mem  [spat_pkg::GDT_DEPTH];
  logic [63:0]              ldt_mem  [spat_pkg::LDT_DEPTH];
  logic                     dir_mem  [spat_pkg::DIR_DEPTH];
  logic [spat_pkg::PTE_W-1:0] ptab_mem [spat_pkg::PTAB_DEPTH];

  spat_pkg::back_state_t    state_r, state_nxt;

  logic [63:0]              gdt_rd_r, ldt_rd_r;
  logic                     dir_rd_r;
  logic [spat_pkg::PTE_W-1:0] pte_rd_r;
  logic                     ti_r;
  logic [31:0]              off_r;
  logic                     dir_in_r, pg_in_r;
  logic [11:0]              low_r;

  logic                     out_valid_r;
  logic [2:0]               fault_r;
  logic [31:0]              phys_r;

  logic                     res_free;
  logic                     res_load;
  spat_pkg::fault_t         res_fault;
  logic [31:0]              res_phys;
  logic                     desc_rd_en, pg_rd_en;
  logic                     gdt_we, ldt_we, dir_we, ptab_we;

  logic [63:0]              desc;
  logic [19:0]              limit_raw;
  logic [31:0]              limit;
  logic [31:0]              base;
  logic [31:0]              lin;
  logic [9:0]               dpos, ppos;
  logic                     dir_in, pg_in;

  assign res_free = !out_valid_r || out_ch.ready;

  // Descriptor decode and linear address
  always_comb begin
    desc      = ti_r ? ldt_rd_r : gdt_rd_r;
    limit_raw = {desc[spat_pkg::DESC_LIM_HI_LSB +: 4], desc[15:0]};
    limit     = desc[spat_pkg::DESC_G_BIT] ? {limit_raw, 12'hFFF} : {12'd0, limit_raw};
    base      = {desc[spat_pkg::DESC_BASE_HI_LSB +: 8], desc[spat_pkg::DESC_BASE_LO_LSB +: 24]};
    lin       = base + off_r;
    dpos      = lin[spat_pkg::DIR_SHIFT +: 10];
    ppos      = lin[spat_pkg::PAGE_SHIFT +: 10];
    dir_in    = ({1'b0, dpos} < dir_count) && ({1'b0, dpos} < 11'(spat_pkg::DIR_DEPTH));
    pg_in     = ({1'b0, ppos} < ptab_count) && ({1'b0, ppos} < 11'(spat_pkg::PTAB_DEPTH));
  end

  always_comb begin
    state_nxt  = state_r;
    pop        = 1'b0;
    res_load   = 1'b0;
    res_fault  = spat_pkg::FLT_OK;
    res_phys   = 32'd0;
    desc_rd_en = 1'b0;
    pg_rd_en   = 1'b0;
    gdt_we     = 1'b0;
    ldt_we     = 1'b0;
    dir_we     = 1'b0;
    ptab_we    = 1'b0;
    case (state_r)
      spat_pkg::B_IDLE: begin
        if (!q_stat.empty) begin
          if (head.kind == spat_pkg::CMD_LOOKUP) begin
            pop        = 1'b1;
            desc_rd_en = 1'b1;
            state_nxt  = spat_pkg::B_DESC;
          end else if (res_free) begin
            pop       = 1'b1;
            res_load  = 1'b1;
            res_fault = head.fault;
            gdt_we    = (head.kind == spat_pkg::CMD_WR_GDT);
            ldt_we    = (head.kind == spat_pkg::CMD_WR_LDT);
            dir_we    = (head.kind == spat_pkg::CMD_WR_DIR);
            ptab_we   = (head.kind == spat_pkg::CMD_WR_PTAB);
          end
        end
      end
      spat_pkg::B_DESC: begin
        if (!desc[spat_pkg::DESC_P_BIT] || off_r > limit) begin
          if (res_free) begin
            res_load  = 1'b1;
            res_fault = !desc[spat_pkg::DESC_P_BIT] ? spat_pkg::FLT_ABSENT
                                                     : spat_pkg::FLT_LIMIT;
            state_nxt = spat_pkg::B_IDLE;
          end
        end else begin
          pg_rd_en  = 1'b1;
          state_nxt = spat_pkg::B_PAGE;
        end
      end
      spat_pkg::B_PAGE: begin
        if (res_free) begin
          res_load  = 1'b1;
          state_nxt = spat_pkg::B_IDLE;
          if (!dir_in_r || !dir_rd_r) begin
            res_fault = spat_pkg::FLT_DIR;
          end else if (!pg_in_r || !pte_rd_r[0]) begin
            res_fault = spat_pkg::FLT_PAGE;
          end else begin
            res_phys = {pte_rd_r[spat_pkg::PTE_W-1:1], low_r};
          end
        end
      end
      default: state_nxt = spat_pkg::B_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= spat_pkg::B_IDLE;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (res_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (res_load) begin
      fault_r <= res_fault;
      phys_r  <= res_phys;
    end
  end

  // Descriptor read port
  always_ff @(posedge clk) begin
    if (desc_rd_en) begin
      gdt_rd_r <= gdt_mem[spat_pkg::GDT_AW'(head.sel_idx)];
      ldt_rd_r <= ldt_mem[spat_pkg::LDT_AW'(head.sel_idx)];
      ti_r     <= head.ti;
      off_r    <= head.seg_offset;
    end
  end

  // Directory and page table read in parallel
  always_ff @(posedge clk) begin
    if (pg_rd_en) begin
      dir_rd_r <= dir_mem[spat_pkg::DIR_AW'(dpos)];
      pte_rd_r <= ptab_mem[spat_pkg::PTAB_AW'(ppos)];
      dir_in_r <= dir_in;
      pg_in_r  <= pg_in;
      low_r    <= lin[spat_pkg::PAGE_SHIFT-1:0];
    end
  end

  always_ff @(posedge clk) begin
    if (gdt_we) begin
      gdt_mem[spat_pkg::GDT_AW'(head.entry_index)] <= head.entry_data;
    end
  end

  always_ff @(posedge clk) begin
    if (ldt_we) begin
      ldt_mem[spat_pkg::LDT_AW'(head.entry_index)] <= head.entry_data;
    end
  end

  always_ff @(posedge clk) begin
    if (dir_we) begin
      dir_mem[spat_pkg::DIR_AW'(head.entry_index)] <= head.entry_data[0];
    end
  end

  // entry keeps present bit and frame number
  always_ff @(posedge clk) begin
    if (ptab_we) begin
      ptab_mem[spat_pkg::PTAB_AW'(head.entry_index)] <=
        {head.entry_data[31:12], head.entry_data[0]};
    end
  end

  assign out_ch.valid     = out_valid_r;
  assign out_ch.fault     = fault_r;
  assign out_ch.phys_addr = phys_r;

endmodule

`default_nettype wire

// File: rtl/core/segmented_paged_address_translator_core.sv
// Segment and page translator. Write items load GDT/LDT descriptors, directory present bits
// and page table entries; translate items check a selector and offset and return a physical
// address or a fault code, one result per item in order. A front stage classifies each item
// (null selector, table index range, write range) and queues it in a two-entry queue; the back
// end owns the tables. Writes and items that fault in the front are answered from the idle
// state; a full translation steps through descriptor memory read, then limit check and base
// add with the directory and page table read together, then the final check. The back end
// works on one item at a time, so the sustained rate is one item per cycle for writes, less
// whenever the result register is not drained. The counts are set over the APB port at byte
// offsets 0, 4, 8 and 12; the user must write them only while the block is idle, which the
// block itself does not enforce. Table entries hold nothing meaningful until written.
`default_nettype none

module segmented_paged_address_translator_core (
  input  logic        clk,
  input  logic        rst_n,
  spat_in_if.sink     in_ch,
  spat_out_if.source  out_ch,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [3:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready
);

  logic [8:0]  gdt_count_r, ldt_count_r;
  logic [10:0] dir_count_r, ptab_count_r;
  logic        cfg_wr;

  logic              q_push, q_pop;
  spat_pkg::cmd_t    q_push_cmd, q_head;
  spat_pkg::q_stat_t q_stat;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      gdt_count_r  <= '0;
      ldt_count_r  <= '0;
      dir_count_r  <= '0;
      ptab_count_r <= '0;
    end else if (cfg_wr) begin
      case (paddr[3:2])
        spat_pkg::REG_GDT_COUNT:  gdt_count_r  <= pwdata[8:0];
        spat_pkg::REG_LDT_COUNT:  ldt_count_r  <= pwdata[8:0];
        spat_pkg::REG_DIR_COUNT:  dir_count_r  <= pwdata[10:0];
        spat_pkg::REG_PTAB_COUNT: ptab_count_r <= pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[3:2])
      spat_pkg::REG_GDT_COUNT:  prdata = {23'd0, gdt_count_r};
      spat_pkg::REG_LDT_COUNT:  prdata = {23'd0, ldt_count_r};
      spat_pkg::REG_DIR_COUNT:  prdata = {21'd0, dir_count_r};
      spat_pkg::REG_PTAB_COUNT: prdata = {21'd0, ptab_count_r};
      default:                  prdata = 32'd0;
    endcase
  end

  spat_front u_front (
    .in_ch     (in_ch),
    .gdt_count (gdt_count_r),
    .ldt_count (ldt_count_r),
    .q_stat    (q_stat),
    .push      (q_push),
    .push_cmd  (q_push_cmd)
  );

  spat_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (q_push),
    .push_cmd (q_push_cmd),
    .pop      (q_pop),
    .head     (q_head),
    .stat     (q_stat)
  );

  spat_back u_back (
    .clk        (clk),
    .rst_n      (rst_n),
    .dir_count  (dir_count_r),
    .ptab_count (ptab_count_r),
    .head       (q_head),
    .q_stat     (q_stat),
    .pop        (q_pop),
    .out_ch     (out_ch)
  );

`ifndef NO_ASSERTIONS
  a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_push |-> !q_stat.full)
    else $error("queue push while full");

  a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> !q_stat.empty)
    else $error("queue pop while empty");

  a_fault_zero_addr: assert property (@(posedge clk) disable iff (!rst_n)
    (out_ch.valid && out_ch.fault != spat_pkg::FLT_OK) |-> (out_ch.phys_addr == 32'd0))
    else $error("faulting transfer carries a nonzero address");
`endif

endmodule

`default_nettype wire

// File: test/segmented_paged_address_translator_core_tb.sv
`timescale 1ns / 100ps

module segmented_paged_address_translator_core_tb;

  localparam int CYCLE_LIMIT = 400000;
  localparam int HOLD_CYCLES = 300;
  localparam int DRAIN_CYCLES = 8;
  localparam logic [2:0] OP_FIRST_UNUSED = 3'd5;
  localparam logic [2:0] OP_LAST_UNUSED = 3'd7;

  typedef struct {
    spat_pkg::fault_t fault;
    logic [31:0]      phys;
  } xlat_result_t;

  logic        clk;
  logic        rst_n;
  logic        psel;
  logic        penable;
  logic        pwrite;
  logic [3:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;

  spat_in_if  in_ch ();
  spat_out_if out_ch ();

  segmented_paged_address_translator_core dut (
    .clk     (clk),
    .rst_n   (rst_n),
    .in_ch   (in_ch),
    .out_ch  (out_ch),
    .psel    (psel),
    .penable (penable),
    .pwrite  (pwrite),
    .paddr   (paddr),
    .pwdata  (pwdata),
    .prdata  (prdata),
    .pready  (pready)
  );

  // Shadow copy of the translator tables and count registers
  logic [63:0]                gdt_tbl [spat_pkg::GDT_DEPTH];
  logic [63:0]                ldt_tbl [spat_pkg::LDT_DEPTH];
  logic                       dir_tbl [spat_pkg::DIR_DEPTH];
  logic [spat_pkg::PTE_W-1:0] pte_tbl [spat_pkg::PTAB_DEPTH];
  // Entries written so far; a translation never reads one that is not
  bit gdt_wr [spat_pkg::GDT_DEPTH];
  bit ldt_wr [spat_pkg::LDT_DEPTH];
  bit dir_wr [spat_pkg::DIR_DEPTH];
  bit pte_wr [spat_pkg::PTAB_DEPTH];
  int gdt_cnt = 0;
  int ldt_cnt = 0;
  int dir_cnt = 0;
  int ptab_cnt = 0;

  xlat_result_t xlat_results_due [$];
  int   mismatches = 0;
  int   cycle_cnt = 0;
  int   in_idle_pct = 0;
  int   out_stall_pct = 0;
  logic hold_active = 1'b0;
  event hold_start;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  always @(posedge clk) begin
    cycle_cnt++;
    if (cycle_cnt == CYCLE_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  always @(negedge clk)
    out_ch.ready <= !hold_active && ($urandom_range(99) >= out_stall_pct);

  always begin
    @(hold_start);
    hold_active = 1'b1;
    repeat (HOLD_CYCLES) @(posedge clk);
    hold_active = 1'b0;
  end

  function automatic logic [31:0] desc_limit(logic [63:0] d);
    logic [31:0] lim;
    lim = {12'h0, d[spat_pkg::DESC_LIM_HI_LSB +: 4], d[15:0]};
    if (d[spat_pkg::DESC_G_BIT])
      lim = {lim[19:0], 12'hFFF};
    return lim;
  endfunction

  function automatic logic [63:0] make_desc(logic [31:0] base, logic [19:0] lim, logic g,
                                            logic p);
    return {base[31:24], g, 3'b000, lim[19:16], p, 7'h00, base[23:0], lim[15:0]};
  endfunction

  function automatic int table_depth(logic [2:0] op);
    case (op)
      spat_pkg::OP_WR_GDT: return spat_pkg::GDT_DEPTH;
      spat_pkg::OP_WR_LDT: return spat_pkg::LDT_DEPTH;
      spat_pkg::OP_WR_DIR: return spat_pkg::DIR_DEPTH;
      default:             return spat_pkg::PTAB_DEPTH;
    endcase
  endfunction

  // Random entry, mostly marked present
  function automatic logic [63:0] random_entry(logic [2:0] op);
    logic [63:0] data;
    data = {$urandom, $urandom};
    if (op == spat_pkg::OP_WR_GDT || op == spat_pkg::OP_WR_LDT)
      data[spat_pkg::DESC_P_BIT] = ($urandom_range(99) < 85);
    else
      data[0] = ($urandom_range(99) < 80);
    return data;
  endfunction

  function automatic xlat_result_t translate_addr(logic [15:0] sel, logic [31:0] off);
    xlat_result_t r;
    logic         ti;
    int           idx;
    logic [63:0]  d;
    logic [31:0]  base;
    logic [31:0]  lin;
    logic [spat_pkg::PTE_W-1:0] pe;
    r.fault = spat_pkg::FLT_OK;
    r.phys = '0;
    ti = sel[2];
    idx = int'(sel[15:3]);
    if (sel == 16'h0 || (!ti && idx == 0)) begin
      r.fault = spat_pkg::FLT_NULL;
      return r;
    end
    if (ti) begin
      if (idx >= ldt_cnt || idx >= spat_pkg::LDT_DEPTH) begin
        r.fault = spat_pkg::FLT_INDEX;
        return r;
      end
      d = ldt_tbl[idx];
    end else begin
      if (idx >= gdt_cnt || idx >= spat_pkg::GDT_DEPTH) begin
        r.fault = spat_pkg::FLT_INDEX;
        return r;
      end
      d = gdt_tbl[idx];
    end
    if (!d[spat_pkg::DESC_P_BIT]) begin
      r.fault = spat_pkg::FLT_ABSENT;
      return r;
    end
    if (off > desc_limit(d)) begin
      r.fault = spat_pkg::FLT_LIMIT;
      return r;
    end
    base = {d[spat_pkg::DESC_BASE_HI_LSB +: 8], d[spat_pkg::DESC_BASE_LO_LSB +: 24]};
    lin = base + off;
    if (int'(lin[31:spat_pkg::DIR_SHIFT]) >= dir_cnt || !dir_tbl[lin[31:spat_pkg::DIR_SHIFT]])
    begin
      r.fault = spat_pkg::FLT_DIR;
      return r;
    end
    pe = pte_tbl[lin[spat_pkg::DIR_SHIFT-1:spat_pkg::PAGE_SHIFT]];
    if (int'(lin[spat_pkg::DIR_SHIFT-1:spat_pkg::PAGE_SHIFT]) >= ptab_cnt || !pe[0]) begin
      r.fault = spat_pkg::FLT_PAGE;
      return r;
    end
    r.phys = {pe[20:1], lin[spat_pkg::PAGE_SHIFT-1:0]};
    return r;
  endfunction

  // Finds the first table entry a translation would read that was never written
  function automatic logic missing_entry(logic [15:0] sel, logic [31:0] off,
                                         output logic [2:0] op, output logic [9:0] eidx);
    logic        ti;
    int          idx;
    logic [63:0] d;
    logic [31:0] base;
    logic [31:0] lin;
    logic [9:0]  dpos;
    logic [9:0]  ppos;
    op = spat_pkg::OP_TRANSLATE;
    eidx = '0;
    ti = sel[2];
    idx = int'(sel[15:3]);
    if (sel == 16'h0 || (!ti && idx == 0))
      return 1'b0;
    if (ti) begin
      if (idx >= ldt_cnt || idx >= spat_pkg::LDT_DEPTH)
        return 1'b0;
      if (!ldt_wr[idx]) begin
        op = spat_pkg::OP_WR_LDT;
        eidx = 10'(idx);
        return 1'b1;
      end
      d = ldt_tbl[idx];
    end else begin
      if (idx >= gdt_cnt || idx >= spat_pkg::GDT_DEPTH)
        return 1'b0;
      if (!gdt_wr[idx]) begin
        op = spat_pkg::OP_WR_GDT;
        eidx = 10'(idx);
        return 1'b1;
      end
      d = gdt_tbl[idx];
    end
    if (!d[spat_pkg::DESC_P_BIT] || off > desc_limit(d))
      return 1'b0;
    base = {d[spat_pkg::DESC_BASE_HI_LSB +: 8], d[spat_pkg::DESC_BASE_LO_LSB +: 24]};
    lin = base + off;
    dpos = lin[31:spat_pkg::DIR_SHIFT];
    ppos = lin[spat_pkg::DIR_SHIFT-1:spat_pkg::PAGE_SHIFT];
    if (int'(dpos) >= dir_cnt)
      return 1'b0;
    if (!dir_wr[dpos]) begin
      op = spat_pkg::OP_WR_DIR;
      eidx = dpos;
      return 1'b1;
    end
    if (!dir_tbl[dpos])
      return 1'b0;
    if (int'(ppos) >= ptab_cnt)
      return 1'b0;
    if (!pte_wr[ppos]) begin
      op = spat_pkg::OP_WR_PTAB;
      eidx = ppos;
      return 1'b1;
    end
    return 1'b0;
  endfunction

  function automatic xlat_result_t predict_result(logic [2:0] op, logic [9:0] eidx,
                                                  logic [63:0] data, logic [15:0] sel,
                                                  logic [31:0] off);
    xlat_result_t r;
    r.fault = spat_pkg::FLT_OK;
    r.phys = '0;
    case (op)
      spat_pkg::OP_TRANSLATE: r = translate_addr(sel, off);
      spat_pkg::OP_WR_GDT: begin
        if (eidx < spat_pkg::GDT_DEPTH) begin
          gdt_tbl[eidx] = data;
          gdt_wr[eidx] = 1'b1;
        end
      end
      spat_pkg::OP_WR_LDT: begin
        if (eidx < spat_pkg::LDT_DEPTH) begin
          ldt_tbl[eidx] = data;
          ldt_wr[eidx] = 1'b1;
        end
      end
      spat_pkg::OP_WR_DIR: begin
        if (eidx < spat_pkg::DIR_DEPTH) begin
          dir_tbl[eidx] = data[0];
          dir_wr[eidx] = 1'b1;
        end
      end
      spat_pkg::OP_WR_PTAB: begin
        if (eidx < spat_pkg::PTAB_DEPTH) begin
          pte_tbl[eidx] = {data[31:12], data[0]};
          pte_wr[eidx] = 1'b1;
        end
      end
      default: ;
    endcase
    return r;
  endfunction

  always @(posedge clk) begin : check_results
    xlat_result_t want;
    if (rst_n && out_ch.valid && out_ch.ready) begin
      if (xlat_results_due.size() == 0) begin
        $error("unexpected result: fault %0d phys_addr %h", out_ch.fault, out_ch.phys_addr);
        mismatches++;
      end else begin
        want = xlat_results_due.pop_front();
        if (out_ch.fault !== want.fault) begin
          $error("fault mismatch: expected %0d, actual %0d", want.fault, out_ch.fault);
          mismatches++;
        end
        if (out_ch.phys_addr !== want.phys) begin
          $error("phys_addr mismatch: expected %h, actual %h", want.phys, out_ch.phys_addr);
          mismatches++;
        end
      end
    end
  end

  // Entered and left at a falling edge; valid stays high into the next item
  task automatic send_item(logic [2:0] op, logic [9:0] eidx, logic [63:0] data,
                           logic [15:0] sel, logic [31:0] off);
    while (in_idle_pct > 0 && $urandom_range(99) < in_idle_pct) begin
      in_ch.valid <= 1'b0;
      @(negedge clk);
    end
    in_ch.valid       <= 1'b1;
    in_ch.opcode      <= op;
    in_ch.entry_index <= eidx;
    in_ch.entry_data  <= data;
    in_ch.selector    <= sel;
    in_ch.seg_offset  <= off;
    @(posedge clk);
    while (!in_ch.ready) @(posedge clk);
    xlat_results_due = {xlat_results_due, predict_result(op, eidx, data, sel, off)};
    @(negedge clk);
  endtask

  task automatic send_translate(logic [15:0] sel, logic [31:0] off);
    send_item(spat_pkg::OP_TRANSLATE, 10'($urandom_range(1023)), {$urandom, $urandom},
              sel, off);
  endtask

  task automatic send_write(logic [2:0] op, logic [9:0] eidx, logic [63:0] data);
    send_item(op, eidx, data, 16'($urandom_range(16'hFFFF)), $urandom);
  endtask

  // Writes whatever entries the translation would read before it is sent
  task automatic fill_entries(logic [15:0] sel, logic [31:0] off);
    logic [2:0] op;
    logic [9:0] eidx;
    while (missing_entry(sel, off, op, eidx))
      send_write(op, eidx, random_entry(op));
  endtask

  task automatic drain_results();
    in_ch.valid <= 1'b0;
    while (xlat_results_due.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  task automatic set_counts(int g, int l, int d, int p);
    int vals [4];
    vals[spat_pkg::REG_GDT_COUNT]  = g;
    vals[spat_pkg::REG_LDT_COUNT]  = l;
    vals[spat_pkg::REG_DIR_COUNT]  = d;
    vals[spat_pkg::REG_PTAB_COUNT] = p;
    for (int i = 0; i < 4; i++) begin
      psel    <= 1'b1;
      penable <= 1'b0;
      pwrite  <= 1'b1;
      paddr   <= {i[1:0], 2'b00};
      pwdata  <= vals[i];
      @(negedge clk);
      penable <= 1'b1;
      @(posedge clk);
      while (!pready) @(posedge clk);
      case (i[1:0])
        spat_pkg::REG_GDT_COUNT:  gdt_cnt = vals[i] & 'h1FF;
        spat_pkg::REG_LDT_COUNT:  ldt_cnt = vals[i] & 'h1FF;
        spat_pkg::REG_DIR_COUNT:  dir_cnt = vals[i] & 'h7FF;
        spat_pkg::REG_PTAB_COUNT: ptab_cnt = vals[i] & 'h7FF;
        default: ;
      endcase
      @(negedge clk);
    end
    psel    <= 1'b0;
    penable <= 1'b0;
    pwrite  <= 1'b0;
  endtask

  task automatic configure(int g, int l, int d, int p, int in_pct, int out_pct);
    drain_results();
    set_counts(g, l, d, p);
    in_idle_pct = in_pct;
    out_stall_pct = out_pct;
  endtask

  // Pick a descriptor that is mostly in range, and an offset mostly near or under its limit
  task automatic random_translate();
    logic        ti;
    int          cnt;
    int          pick;
    logic [12:0] sidx;
    logic [1:0]  rpl;
    logic [15:0] sel;
    logic [31:0] lim;
    logic [31:0] off;
    ti = 1'($urandom_range(1));
    rpl = 2'($urandom_range(3));
    if (ti)
      cnt = (ldt_cnt < spat_pkg::LDT_DEPTH) ? ldt_cnt : spat_pkg::LDT_DEPTH;
    else
      cnt = (gdt_cnt < spat_pkg::GDT_DEPTH) ? gdt_cnt : spat_pkg::GDT_DEPTH;
    if (cnt > 0 && $urandom_range(99) < 85)
      sidx = 13'($urandom_range(cnt - 1));
    else
      sidx = 13'($urandom_range(8191));
    sel = ($urandom_range(99) < 2) ? 16'h0 : {sidx, ti, rpl};
    off = $urandom;
    if (sel != 16'h0 && sidx < cnt) begin
      if (ti && !ldt_wr[sidx])
        send_write(spat_pkg::OP_WR_LDT, 10'(sidx), random_entry(spat_pkg::OP_WR_LDT));
      if (!ti && !gdt_wr[sidx])
        send_write(spat_pkg::OP_WR_GDT, 10'(sidx), random_entry(spat_pkg::OP_WR_GDT));
      lim = desc_limit(ti ? ldt_tbl[sidx] : gdt_tbl[sidx]);
      pick = $urandom_range(99);
      if (pick < 65)
        off = (lim == '1) ? $urandom : $urandom_range(lim);
      else if (pick < 75)
        off = lim;
      else if (pick < 85)
        off = lim + 1;
    end
    fill_entries(sel, off);
    send_translate(sel, off);
  endtask

  task automatic random_item();
    int          pick;
    int          depth;
    logic [2:0]  op;
    logic [9:0]  eidx;
    pick = $urandom_range(99);
    if (pick < 62) begin
      random_translate();
    end else if (pick < 96) begin
      if (pick < 70)
        op = spat_pkg::OP_WR_GDT;
      else if (pick < 76)
        op = spat_pkg::OP_WR_LDT;
      else if (pick < 85)
        op = spat_pkg::OP_WR_DIR;
      else
        op = spat_pkg::OP_WR_PTAB;
      depth = table_depth(op);
      if (depth < 1024 && $urandom_range(9) == 0)
        eidx = 10'($urandom_range(1023, depth));
      else
        eidx = 10'($urandom_range(depth - 1));
      send_write(op, eidx, random_entry(op));
    end else begin
      op = 3'($urandom_range(OP_LAST_UNUSED, OP_FIRST_UNUSED));
      send_item(op, 10'($urandom_range(1023)), {$urandom, $urandom},
                16'($urandom_range(16'hFFFF)), $urandom);
    end
  endtask

  task automatic test_selector_checks();
    send_translate(16'h0000, 32'h0);
    send_translate(16'h0003, $urandom);        // GDT index 0 with nonzero RPL is still null
    send_translate(16'hFFFF, 32'h0);           // LDT index far past the table
    send_translate({13'd256, 1'b0, 2'b00}, 32'hFFFFFFFF);
  endtask

  task automatic test_segment_checks();
    send_write(spat_pkg::OP_WR_DIR, 0, 64'h1);
    send_write(spat_pkg::OP_WR_PTAB, 0, {32'h0, 20'h12345, 11'h0, 1'b1});
    send_write(spat_pkg::OP_WR_PTAB, 1, {32'hFFFFFFFF, 20'hFFFFF, 11'h7FF, 1'b1});
    send_write(spat_pkg::OP_WR_GDT, 5, make_desc(32'h0, 20'hFFFFF, 1'b1, 1'b0));
    send_translate({13'd5, 1'b0, 2'b00}, 32'h0);
    // granular limit of 1 covers offsets up to 0x1FFF
    send_write(spat_pkg::OP_WR_GDT, 6, make_desc(32'h0, 20'h00001, 1'b1, 1'b1));
    send_translate({13'd6, 1'b0, 2'b00}, 32'h00001FFF);
    send_translate({13'd6, 1'b0, 2'b00}, 32'h00002000);
    // base plus offset wraps past 4 GiB
    send_write(spat_pkg::OP_WR_GDT, 7, make_desc(32'h00000010, 20'hFFFFF, 1'b1, 1'b1));
    send_translate({13'd7, 1'b0, 2'b00}, 32'hFFFFFFF8);
  endtask

  task automatic test_paging_checks();
    send_write(spat_pkg::OP_WR_DIR, 1, 64'h0);
    send_write(spat_pkg::OP_WR_DIR, 1023, 64'hFFFFFFFFFFFFFFFF);
    send_write(spat_pkg::OP_WR_PTAB, 2, {32'h0, 20'hABCDE, 11'h0, 1'b0});
    send_write(spat_pkg::OP_WR_PTAB, 1023, {32'h0, 20'h0, 11'h0, 1'b1});
    send_write(spat_pkg::OP_WR_LDT, 0, make_desc(32'hFFC00000, 20'hFFFFF, 1'b1, 1'b1));
    send_translate(16'h0004, 32'h003FF123);    // last directory slot, last page
    send_translate({13'd7, 1'b0, 2'b00}, 32'h003FFFF0);
    send_translate({13'd7, 1'b0, 2'b00}, 32'h00001FF0);
  endtask

  task automatic test_ignored_items();
    send_write(spat_pkg::OP_WR_GDT, 300, make_desc(32'h0, 20'h0, 1'b0, 1'b0));
    for (int op = OP_FIRST_UNUSED; op <= OP_LAST_UNUSED; op++)
      send_item(3'(op), 10'h3FF, {$urandom, $urandom}, 16'hFFFF, 32'hFFFFFFFF);
  endtask

  task automatic test_random(int n);
    repeat (n) random_item();
  endtask

  // Receiver holds off while items keep coming, so the input side stalls
  task automatic test_backpressure();
    in_idle_pct = 0;
    -> hold_start;
    repeat (40) random_item();
  endtask

  initial begin
    rst_n             = 1'b0;
    psel              = 1'b0;
    penable           = 1'b0;
    pwrite            = 1'b0;
    paddr             = '0;
    pwdata            = '0;
    in_ch.valid       = 1'b0;
    in_ch.opcode      = spat_pkg::OP_TRANSLATE;
    in_ch.entry_index = '0;
    in_ch.entry_data  = '0;
    in_ch.selector    = '0;
    in_ch.seg_offset  = '0;
    out_ch.ready      = 1'b0;
    repeat (8) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    configure(spat_pkg::GDT_DEPTH, spat_pkg::LDT_DEPTH, spat_pkg::DIR_DEPTH,
              spat_pkg::PTAB_DEPTH, 0, 0);
    test_selector_checks();
    test_segment_checks();
    test_paging_checks();
    test_ignored_items();

    test_backpressure();
    test_random(300);
    configure(511, 511, 2047, 2047, 47, 0);
    test_random(280);
    configure(37, 200, 700, 513, 0, 47);
    test_random(280);
    configure(0, 0, 0, 0, 19, 19);
    test_random(70);
    configure(1, 1, 1, 1, 19, 19);
    test_random(70);
    configure(spat_pkg::GDT_DEPTH, spat_pkg::LDT_DEPTH, spat_pkg::DIR_DEPTH,
              spat_pkg::PTAB_DEPTH, 19, 19);
    test_random(200);

    drain_results();
    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule

// File: files.f
rtl/core/spat_pkg.sv
rtl/core/spat_if.sv
rtl/core/spat_front.sv
rtl/core/spat_queue.sv
rtl/core/spat_back.sv
rtl/core/segmented_paged_address_translator_core.sv
test/segmented_paged_address_translator_core_tb.sv
